[rtl/core/olad_pkg.sv]
package olad_pkg;

   // list geometry
   localparam int CAPACITY_DEFAULT = 16;
   localparam int MAX_RESULTS      = 16;
   localparam int QUEUE_DEPTH      = 2;

   // field widths
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;

   // action codes (code 3 means nothing and is dropped)
   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_INVALID = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   // back end sequencer
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // command handed from front to back
   typedef struct packed {
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } cmd_type;

endpackage

[rtl/core/olad_req_if.sv]
interface olad_req_if import olad_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, action, value, index, input ready);
   modport sink (input valid, action, value, index, output ready);
endinterface

[rtl/core/olad_rsp_if.sv]
interface olad_rsp_if import olad_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] value_out;
   logic [POS_W-1:0]          position;
   logic                      last;

   modport source (output valid, status, value_out, position, last, input ready);
   modport sink (input valid, status, value_out, position, last, output ready);
endinterface

[rtl/core/ordered_list_append_delete_at_index.sv]
// channel | dir | handshake          | word
// req_if  | in  | valid / ready      | action, value, index
// rsp_if  | out | valid / ready      | status, value_out, position, last
//
// append and delete are carried out in the back end; read-out emits one entry
// per cycle unless the result stalls, min(count, 16) entries, set by the single
// result register. a command first passes through the two-word command queue.
// reset empties the list and the queue; stored values are not cleared.
// a stalled result only holds the back end; the front keeps taking words
// until the queue is full.
module ordered_list_append_delete_at_index import olad_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   olad_req_if.sink   req_if,
   olad_rsp_if.source rsp_if
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // accept and queue
   olad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // list and result sequencing
   olad_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_if    (rsp_if)
   );

endmodule

[rtl/core/olad_front.sv]
module olad_front import olad_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   olad_req_if.sink       req_if,
   output logic           cmd_valid,
   output cmd_type        cmd,
   input  logic           cmd_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               accept;
   logic               push;
   logic               meaningful;

   // classify the incoming word; unused action code is taken and dropped
   always_comb begin
      unique case (req_if.action)
         ACT_APPEND, ACT_DELETE, ACT_READ: meaningful = 1'b1;
         default:                          meaningful = 1'b0;
      endcase
   end

   assign req_if.ready = (occ_ff != OCC_W'(QUEUE_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign push         = accept && meaningful;

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{act: req_if.action, value: req_if.value,
                                  index: req_if.index};
      end
   end

   assign cmd_valid = (occ_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

[rtl/core/olad_back.sv]
module olad_back import olad_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   input  cmd_type        cmd,
   output logic           cmd_pop,
   olad_rsp_if.source     rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic signed [VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic [IDX_W-1:0]          last_k;
   state_type                 state_ff, state_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      last_ff, last_in;
   logic                      emit;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // index of the final entry a read-out emits
   always_comb begin
      if (32'(count_ff) > MAX_RESULTS) begin
         last_k = IDX_W'(MAX_RESULTS - 1);
      end else begin
         last_k = IDX_W'(count_ff - 1'b1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free && cmd.act == ACT_READ &&
                count_ff != '0 && last_k != '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free && k_ff == last_k) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // actions and result word
   always_comb begin
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      status_in  = STAT_OK;
      value_in   = '0;
      pos_in     = '0;
      last_in    = 1'b1;
      count_in   = count_ff;
      k_in       = k_ff;
      entries_in = entries_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               emit    = 1'b1;
               priority if (cmd.act == ACT_APPEND) begin
                  if (32'(count_ff) >= CAPACITY) begin
                     status_in = STAT_FULL;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (i == int'(count_ff)) begin
                           entries_in[i] = cmd.value;
                        end
                     end
                     count_in = count_ff + 1'b1;
                  end
               end else if (cmd.act == ACT_DELETE) begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else if (32'(cmd.index) >= 32'(count_ff)) begin
                     status_in = STAT_INVALID;
                  end else begin
                     // close the gap: every entry from the index takes its successor
                     for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (i >= int'(cmd.index)) begin
                           entries_in[i] = entries_ff[i+1];
                        end
                     end
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  // read-out, first entry goes out right away
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     value_in = entries_ff[0];
                     last_in  = (last_k == '0);
                     k_in     = IDX_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               emit     = 1'b1;
               value_in = entries_ff[k_ff];
               pos_in   = POS_W'(k_ff);
               last_in  = (k_ff == last_k);
               k_in     = k_ff + 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // output word handshake
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // list storage and result payload
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (emit) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         pos_ff    <= pos_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.value_out = value_ff;
   assign rsp_if.position  = pos_ff;
   assign rsp_if.last      = last_ff;

endmodule

[rtl/core/olad_checker.sv]
module olad_checker import olad_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_value_out,
   input logic [POS_W-1:0]    rsp_position,
   input logic                rsp_last
);

   // a stalled result word stays valid with its position and last flag held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // status-only words carry zero value and position and close the item
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_value_out == '0 && rsp_position == '0 && rsp_last)
      else $error("status word with payload or without last");

   // only read-out entries may leave last low, and they are ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STAT_OK)
      else $error("non-final word with error status");

   // read-out streams positions back to back
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_position == POS_W'($past(rsp_position) + 1'b1))
      else $error("read-out gap or position skip");

endmodule

bind ordered_list_append_delete_at_index olad_checker u_olad_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_value_out (rsp_if.value_out),
   .rsp_position  (rsp_if.position),
   .rsp_last      (rsp_if.last)
);
